### hw/rtl/dra_pkg.sv
`default_nettype none

package dra_pkg;

  // field widths
  localparam int TICK_W   = 32;
  localparam int PERIOD_W = 10;
  localparam int MIN_W    = 16;
  localparam int LEAD_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // serial divider for the average
  localparam int REM_W  = 16;
  localparam int DQ_W   = 32;
  localparam int CNT_W  = 5;
  localparam logic [REM_W-1:0] MS_PER_MIN    = 16'd60000;
  localparam logic [LEAD_W-1:0] LEAD_CAP     = 8'd255;

  // ms to minutes: 60000 = 1875 << 5, so drop five low bits and multiply
  // by ceil(2^38 / 1875); exact for every 27-bit dividend
  localparam int                 DIV_SHIFT  = 5;
  localparam int                 RECIP_W    = 28;
  localparam int                 RECIP_SH   = 38;
  localparam logic [RECIP_W-1:0] RECIP_1875 = 28'd146601551;
  localparam int                 SCALE_W    = TICK_W - DIV_SHIFT + RECIP_W;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK_PERIOD  = 2'd0,
    REG_MAX_VALID    = 2'd1,
    REG_MARGIN       = 2'd2,
    REG_DEFAULT_LEAD = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_STARTED  = 2'd0,
    ST_RECORDED = 2'd1,
    ST_IMPLAUS  = 2'd2,
    ST_NOSTART  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_TAKE,
    OP_START,
    OP_NOSTART,
    OP_MUL,
    OP_SCALE,
    OP_DSTEP,
    OP_CHECK,
    OP_RECORD,
    OP_SUMCLR,
    OP_ACC,
    OP_LDAVG,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_IS_START,
    C_NO_SESSION,
    C_CNT_MORE,
    C_BAD_MIN,
    C_EMPTY,
    C_IDX_MORE,
    C_OUT_BUSY
  } cond_t;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_WAIT   = 4'd0;
  localparam pc_t PC_SUM    = 4'd7;
  localparam pc_t PC_ACC    = 4'd8;
  localparam pc_t PC_DIVAVG = 4'd10;
  localparam pc_t PC_EMIT   = 4'd11;
  localparam pc_t PC_LAST   = 4'd11;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  // control store
  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t w;
    unique case (pc)
      4'd0:    w = '{OP_TAKE,    C_NO_IN,      PC_WAIT};
      4'd1:    w = '{OP_START,   C_IS_START,   PC_SUM};
      4'd2:    w = '{OP_NOSTART, C_NO_SESSION, PC_SUM};
      4'd3:    w = '{OP_MUL,     C_NEVER,      PC_WAIT};
      4'd4:    w = '{OP_SCALE,   C_NEVER,      PC_WAIT};
      4'd5:    w = '{OP_CHECK,   C_BAD_MIN,    PC_SUM};
      4'd6:    w = '{OP_RECORD,  C_NEVER,      PC_WAIT};
      4'd7:    w = '{OP_SUMCLR,  C_EMPTY,      PC_EMIT};
      4'd8:    w = '{OP_ACC,     C_IDX_MORE,   PC_ACC};
      4'd9:    w = '{OP_LDAVG,   C_NEVER,      PC_WAIT};
      4'd10:   w = '{OP_DSTEP,   C_CNT_MORE,   PC_DIVAVG};
      4'd11:   w = '{OP_EMIT,    C_OUT_BUSY,   PC_EMIT};
      default: w = '{OP_NOP,     C_ALWAYS,     PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/duration_rolling_average.sv
// channel  dir  beat fields (tdata / tuser, low bit up)      accepted when
// in       in   tdata: now_tick[31:0]  tuser: func[0]         in_tvalid & in_tready
// out      out  tdata: lead_minutes[7:0]  tuser: status[1:0]  out_tvalid & out_tready
// cfg      in   cfg_index: register, cfg_data: value         cfg_valid & cfg_ready
//
// one event at a time, run by a 12-step control store; ready again in the cycle after emit
// start: store the tick, then sum, divide and emit (no sum or divide when history is empty)
// end: check for an open session; if there is one, the duration steps run before the sum
//   (multiply, reciprocal scale to minutes, check, record; a dropped duration skips record)
// at depth 5 (SUM_W = 19) an event's time is set by the bit-serial average divide and
//   the one-entry-per-cycle history sum
// reset is synchronous active low; clears session, history fill and registers to defaults
// a result waiting on out_tready stalls only the emit step; cfg is always ready

`default_nettype none

module duration_rolling_average #(
  parameter int HISTORY_DEPTH = 5
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [dra_pkg::TICK_W-1:0]      in_tdata,   // now_tick[31:0]
  input  wire logic                            in_tuser,   // func[0]
  // result stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [dra_pkg::LEAD_W-1:0]           out_tdata,  // lead_minutes[7:0]
  output logic [1:0]                           out_tuser,  // status[1:0]
  // configuration writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [dra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dra_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dra_pkg::*;

  localparam int IDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  // sum of up to HISTORY_DEPTH 16-bit entries
  localparam int SUM_W  = MIN_W + $clog2(HISTORY_DEPTH);
  localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(HISTORY_DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL      = FILL_W'(HISTORY_DEPTH);

  // sequencer
  pc_t    pc_r, pc_nxt;
  uword_t uw;
  logic   jump;

  // configuration
  logic [PERIOD_W-1:0] period_r;
  logic [MIN_W-1:0]    max_min_r;
  logic [LEAD_W-1:0]   margin_r;
  logic [LEAD_W-1:0]   dflt_r;

  // event state
  logic                func_r;
  logic [TICK_W-1:0]   now_r;
  logic [TICK_W-1:0]   start_r;
  logic [MIN_W-1:0]    history_r [HISTORY_DEPTH];
  logic [IDX_W-1:0]    slot_r;
  logic [FILL_W-1:0]   filled_r;
  status_t             status_r;

  // datapath
  logic [TICK_W-1:0]   prod_r;
  logic [SUM_W-1:0]    sum_r;
  logic [IDX_W-1:0]    idx_r;
  logic [REM_W-1:0]    rem_r;
  logic [DQ_W-1:0]     dq_r;
  logic [REM_W-1:0]    div_r;
  logic [CNT_W-1:0]    cnt_r;

  // output register
  logic                out_valid_r;
  logic [LEAD_W-1:0]   out_lead_r;
  status_t             out_status_r;

  logic [TICK_W-1:0]          elapsed;
  logic [TICK_W+PERIOD_W-1:0] mul_full;
  logic [SCALE_W-1:0]         scale_full;
  logic [REM_W:0]             div_sh;
  logic [REM_W:0]             div_sub;
  logic                       div_ge;
  logic [MIN_W-1:0]           minutes;
  logic                       bad_min;
  logic [MIN_W:0]             lead_sum;
  logic [LEAD_W-1:0]          lead_val;
  logic                       out_busy;

  assign uw       = ucode_rom(pc_r);
  assign in_tready = (uw.op == OP_TAKE);
  assign cfg_ready = 1'b1;
  assign out_busy  = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_lead_r;
  assign out_tuser  = out_status_r;

  // elapsed ticks times period, wrapped to 32 bits
  assign elapsed  = now_r - start_r;
  assign mul_full = {{PERIOD_W{1'b0}}, elapsed} * {{TICK_W{1'b0}}, period_r};

  // ms / 60000 as (ms >> 5) times the scaled reciprocal of 1875
  assign scale_full = SCALE_W'(prod_r[TICK_W-1:DIV_SHIFT]) * SCALE_W'(RECIP_1875);

  // restoring divider for the average, one quotient bit per step
  assign div_sh  = {rem_r, dq_r[DQ_W-1]};
  assign div_ge  = div_sh >= {1'b0, div_r};
  assign div_sub = div_sh - {1'b0, div_r};

  assign minutes = dq_r[MIN_W-1:0];
  assign bad_min = (minutes == '0) || (minutes > max_min_r);

  // average plus margin, clipped at the lead cap; the default lead when history is empty
  assign lead_sum = {1'b0, minutes} + (MIN_W+1)'(margin_r);
  assign lead_val = (filled_r == '0) ? dflt_r :
                    (lead_sum > (MIN_W+1)'(LEAD_CAP)) ? LEAD_CAP : lead_sum[LEAD_W-1:0];

  // branch conditions
  always_comb begin
    unique case (uw.cond)
      C_NEVER:      jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_NO_IN:      jump = !in_tvalid;
      C_IS_START:   jump = !func_r;
      C_NO_SESSION: jump = (start_r == '0);
      C_CNT_MORE:   jump = (cnt_r != CNT_W'(1));
      C_BAD_MIN:    jump = bad_min;
      C_EMPTY:      jump = (filled_r == '0);
      C_IDX_MORE:   jump = ((FILL_W'(idx_r) + FILL_W'(1)) != filled_r);
      C_OUT_BUSY:   jump = out_busy;
      default:      jump = 1'b0;
    endcase
  end

  always_comb begin
    if (jump) begin
      pc_nxt = uw.target;
    end else if (pc_r == PC_LAST) begin
      pc_nxt = PC_WAIT;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_WAIT;
      out_valid_r <= 1'b0;
      start_r     <= '0;
      slot_r      <= '0;
      filled_r    <= '0;
      period_r    <= PERIOD_W'(1);
      max_min_r   <= MIN_W'(180);
      margin_r    <= LEAD_W'(10);
      dflt_r      <= LEAD_W'(30);
    end else begin
      pc_r <= pc_nxt;

      // the emit step reloads the beat itself
      if (out_valid_r && out_tready && (uw.op != OP_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (reg_idx_t'(cfg_index))
          REG_TICK_PERIOD:  period_r  <= cfg_data[PERIOD_W-1:0];
          REG_MAX_VALID:    max_min_r <= cfg_data[MIN_W-1:0];
          REG_MARGIN:       margin_r  <= cfg_data[LEAD_W-1:0];
          REG_DEFAULT_LEAD: dflt_r    <= cfg_data[LEAD_W-1:0];
          default: ;
        endcase
      end

      unique case (uw.op)
        OP_START: begin
          if (!func_r) begin
            start_r <= now_r;
          end
        end
        OP_MUL: start_r <= '0;
        OP_RECORD: begin
          slot_r <= (slot_r == LAST_SLOT) ? '0 : slot_r + IDX_W'(1);
          if (filled_r != FULL) begin
            filled_r <= filled_r + FILL_W'(1);
          end
        end
        OP_EMIT: begin
          if (!out_busy) begin
            out_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    unique case (uw.op)
      OP_TAKE: begin
        if (in_tvalid) begin
          func_r <= in_tuser;
          now_r  <= in_tdata;
        end
      end
      OP_START: begin
        if (!func_r) begin
          status_r <= ST_STARTED;
        end
      end
      OP_NOSTART: status_r <= ST_NOSTART;
      OP_MUL:     prod_r   <= mul_full[TICK_W-1:0];
      // quotient has at most 17 bits, minutes keep the low 16
      OP_SCALE:   dq_r     <= DQ_W'(scale_full[SCALE_W-1:RECIP_SH]);
      OP_DSTEP: begin
        rem_r <= div_ge ? div_sub[REM_W-1:0] : div_sh[REM_W-1:0];
        dq_r  <= {dq_r[DQ_W-2:0], div_ge};
        cnt_r <= cnt_r - CNT_W'(1);
      end
      OP_CHECK:  status_r <= bad_min ? ST_IMPLAUS : ST_RECORDED;
      OP_RECORD: history_r[slot_r] <= minutes;
      OP_SUMCLR: begin
        sum_r <= '0;
        idx_r <= '0;
      end
      OP_ACC: begin
        sum_r <= sum_r + SUM_W'(history_r[idx_r]);
        idx_r <= idx_r + IDX_W'(1);
      end
      OP_LDAVG: begin
        rem_r <= '0;
        dq_r  <= {sum_r, {(DQ_W-SUM_W){1'b0}}};
        div_r <= REM_W'(filled_r);
        cnt_r <= CNT_W'(SUM_W);
      end
      OP_EMIT: begin
        if (!out_busy) begin
          out_lead_r   <= lead_val;
          out_status_r <= status_r;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/dra_checker.sv
`default_nettype none

module dra_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [dra_pkg::TICK_W-1:0]      in_tdata,
  input wire logic                            in_tuser,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [dra_pkg::LEAD_W-1:0]      out_tdata,
  input wire logic [1:0]                      out_tuser,
  input wire logic                            cfg_valid,
  input wire logic                            cfg_ready,
  input wire logic [dra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input wire logic [dra_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dra_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // one event in flight: no new beat right after an accept
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready directly after accept");

  // a new result comes from the emit step, never from the wait step
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared while waiting for input");

  // reset drops the result channel
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind duration_rolling_average dra_checker u_dra_checker (.*);

`default_nettype wire

### verif/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dra_pkg::*;

  localparam int DEPTH       = 5;
  localparam int LIMIT       = 1_000_000;  // watchdog, in clock cycles
  localparam int HOLD_CYCLES = 300;        // long receiver hold-off
  localparam int SETTLE      = 60;         // more than one worst-case event time

  // one expected result beat
  typedef struct {
    logic [LEAD_W-1:0] lead;
    status_t           status;
  } lead_beat_t;

  // mirror of the block: session, duration ring, registers, pending results
  class lead_tracker;
    logic [MIN_W-1:0]    hist [DEPTH];
    int unsigned         slot;
    int unsigned         fill;
    logic [TICK_W-1:0]   session_start;
    logic [PERIOD_W-1:0] period;
    logic [MIN_W-1:0]    max_min;
    logic [LEAD_W-1:0]   margin;
    logic [LEAD_W-1:0]   dflt_lead;
    lead_beat_t          due [$];
    int                  errors;
    int                  reported;

    function new();
      foreach (hist[i]) hist[i] = '0;
      slot          = 0;
      fill          = 0;
      session_start = '0;
      period        = 10'd1;
      max_min       = 16'd180;
      margin        = 8'd10;
      dflt_lead     = 8'd30;
      errors        = 0;
      reported      = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_TICK_PERIOD:  period    = val[PERIOD_W-1:0];
        REG_MAX_VALID:    max_min   = val[MIN_W-1:0];
        REG_MARGIN:       margin    = val[LEAD_W-1:0];
        REG_DEFAULT_LEAD: dflt_lead = val[LEAD_W-1:0];
        default: ;
      endcase
    endfunction

    // average of the filled part of the ring plus margin, capped
    function logic [LEAD_W-1:0] lead_now();
      int unsigned sum;
      int unsigned avg;
      if (fill == 0) return dflt_lead;
      sum = 0;
      for (int i = 0; i < fill; i++) sum += hist[i];
      avg = sum / fill + margin;
      return (avg > 32'(LEAD_CAP)) ? LEAD_CAP : LEAD_W'(avg);
    endfunction

    function void note_event(logic is_end, logic [TICK_W-1:0] now);
      logic [31:0]      ms;
      logic [MIN_W-1:0] mins;
      status_t          st;
      lead_beat_t       beat;
      if (!is_end) begin
        session_start = now;
        st = ST_STARTED;
      end else if (session_start == '0) begin
        st = ST_NOSTART;
      end else begin
        // elapsed ticks times period wraps at 32 bits, minutes truncate to 16
        ms   = (now - session_start) * 32'(period);
        mins = MIN_W'(ms / 32'(MS_PER_MIN));
        session_start = '0;
        if (mins == '0 || mins > max_min) begin
          st = ST_IMPLAUS;
        end else begin
          hist[slot] = mins;
          slot = (slot == DEPTH - 1) ? 0 : slot + 1;
          if (fill < DEPTH) fill++;
          st = ST_RECORDED;
        end
      end
      beat.lead   = lead_now();
      beat.status = st;
      due.push_back(beat);
    endfunction

    function void check_result(logic [LEAD_W-1:0] lead, status_t st);
      lead_beat_t want;
      if (due.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("unexpected result beat: lead %0d status %s", lead, st.name());
        end
        return;
      end
      want = due.pop_front();
      if (want.lead !== lead || want.status !== st) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("result mismatch: lead exp %0d got %0d, status exp %s got %s",
                   want.lead, lead, want.status.name(), st.name());
        end
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  // dut signals; the driven inputs are all known from time zero
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [TICK_W-1:0]     in_tdata   = '0;   // now_tick[31:0]
  logic                  in_tuser   = 1'b0; // func[0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [LEAD_W-1:0]     out_tdata;         // lead_minutes[7:0]
  logic [1:0]            out_tuser;         // status[1:0]
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  reg_idx_t              cfg_index  = REG_TICK_PERIOD;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  lead_tracker board = new();

  // stimulus-side view of the registers, used to aim durations
  logic [PERIOD_W-1:0] cur_period = 10'd1;
  logic [MIN_W-1:0]    cur_max    = 16'd180;

  int burst_left  = 0;  // beats left in the current sender burst
  int holds_asked = 0;  // long hold-offs requested by the sender side
  int holds_done  = 0;  // long hold-offs carried out by the receiver
  int cycle_count = 0;

  duration_rolling_average #(
    .HISTORY_DEPTH (DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // monitor: every accepted beat goes to the tracker, values as seen at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) board.note_event(in_tuser, in_tdata);
      if (out_tvalid && out_tready) board.check_result(out_tdata, status_t'(out_tuser));
    end
  end

  // receiver: stretches of always ready, coin flip, or mostly stalled,
  // plus long hold-offs on request so the block backs up into its input
  initial begin
    int mode;
    int mode_left;
    mode      = 0;
    mode_left = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (holds_done != holds_asked) begin
        out_tready <= 1'b0;
        holds_done++;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(8, 120);
        end
        mode_left--;
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 1) == 1);
          default: out_tready <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // offer one event beat and wait until it is taken; sender runs in bursts,
  // gaps of zero up to longer than one event so they land on every step
  task automatic send_event(input logic is_end, input logic [TICK_W-1:0] now);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2:    gap = 0;
        3, 4, 5, 6: gap = $urandom_range(1, 15);
        default:    gap = $urandom_range(20, 80);
      endcase
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= now;
    in_tuser  <= is_end;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_session(input logic [TICK_W-1:0] t0, input logic [TICK_W-1:0] span);
    send_event(1'b0, t0);
    send_event(1'b1, t0 + span);
  endtask

  // stop offering and wait for every expected result; the first edge lets
  // the monitor log a beat accepted at this very edge
  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val,
                           input bit last_one);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (last_one) cfg_valid <= 1'b0;
  endtask

  // all four registers, only with the block idle
  task automatic set_config(input logic [CFG_DATA_W-1:0] period_v, max_v, margin_v, dflt_v);
    wait_results_done();
    repeat (8) @(posedge clk);
    write_reg(REG_TICK_PERIOD,  period_v, 1'b0);
    write_reg(REG_MAX_VALID,    max_v,    1'b0);
    write_reg(REG_MARGIN,       margin_v, 1'b0);
    write_reg(REG_DEFAULT_LEAD, dflt_v,   1'b1);
    cur_period = period_v[PERIOD_W-1:0];
    cur_max    = max_v;
  endtask

  // tick span aimed at an interesting number of minutes for the current setup
  function automatic logic [TICK_W-1:0] pick_span();
    int unsigned     target;
    longint unsigned ms;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: target = $urandom_range(1, (cur_max < 400) ? cur_max : 400);
      4, 5:       target = cur_max + $urandom_range(0, 1);  // edge of the valid range
      6:          target = 0;
      7:          target = $urandom_range(0, 71582);        // past 16 bits of minutes
      default:    return $urandom;
    endcase
    if (cur_period == '0) return $urandom;
    ms = longint'(target) * 60000 + $urandom_range(0, 59999);
    return TICK_W'(ms / cur_period);
  endfunction

  // mostly well-formed sessions with random content, some stray ends and starts
  task automatic random_phase(input int n_items);
    int          sent;
    int          pick;
    logic [31:0] t0;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        t0 = $urandom;
        send_session(t0, pick_span());
        sent += 2;
      end else if (pick < 84) begin
        send_event(1'b1, $urandom);
        sent++;
      end else if (pick < 93) begin
        send_event(1'b0, $urandom);
        sent++;
      end else if (pick < 96) begin
        send_event(1'b0, '0);  // start at tick zero leaves no open session
        sent++;
      end else if (pick < 97) begin
        holds_asked++;
      end else begin
        wait_results_done();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset register values first
    send_event(1'b1, 32'd5);               // end with nothing open, default lead
    set_config(16'd1, 16'd180, 16'd10, 16'd255);
    send_event(1'b1, $urandom);
    set_config(16'd1, 16'd180, 16'd10, 16'd0);
    send_event(1'b0, '0);                  // start at tick zero
    send_event(1'b1, 32'd600000);          // so this end sees no session
    set_config(16'd1, 16'd180, 16'd10, 16'd30);
    send_event(1'b0, 32'd100);             // repeated start: the later one counts
    send_session(32'd200, 32'd299950);     // 4 minutes from the later start
    send_session(32'd1000, 32'd59999);     // rounds to zero minutes
    send_session($urandom, 32'd10800000);  // exactly the maximum
    send_session($urandom, 32'd10860000);  // one minute over
    send_session(32'hFFFF_FFF0, 32'd600000);  // tick counter wraps
    send_session(32'hFFFF_FFFF, 32'd120001);
    send_session($urandom, 32'd60000);     // ring now full
    send_session($urandom, 32'd10740000);  // ring wraps to slot zero
    send_event(1'b1, $urandom);

    // period of 1000, largest limits, saturating lead; long hold-off early on
    set_config(16'd1000, 16'hFFFF, 16'd255, 16'd255);
    holds_asked++;
    random_phase(100);

    // zero tick period: every closed session is implausible
    set_config(16'd0, 16'd180, 16'd0, 16'd0);
    random_phase(100);

    // tightest limit: only one-minute sessions are kept
    set_config(16'd1, 16'd1, 16'd0, 16'd0);
    random_phase(100);

    // random settings, unused upper data bits random too
    repeat (2) begin
      set_config(16'($urandom), 16'($urandom_range(1, 600)), 16'($urandom), 16'($urandom));
      random_phase(100);
    end

    wait_results_done();
    repeat (SETTLE) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
hw/rtl/dra_pkg.sv
hw/rtl/duration_rolling_average.sv
hw/rtl/dra_checker.sv
verif/testbench.sv
